// ----- rtl/core/xvse_pkg.sv -----
`timescale 1ns / 1ps
// Package for the XOR value stream encoder: shared constants, the queue item
// type and the zero-count functions. Depends on nothing.
package xvse_pkg;

  localparam int WordBits      = 64;
  localparam int ScopeBits     = 6;
  localparam int CountBits     = 7;
  localparam int PrefixBits    = 14;
  localparam int PrefixLenBits = 4;

  typedef enum logic [1:0] {
    KIND_RAW  = 2'd0,
    KIND_SAME = 2'd1,
    KIND_DIFF = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t                 kind;
    logic [WordBits-1:0]   value;
    logic [ScopeBits-1:0]  lead;
    logic [ScopeBits-1:0]  trail;
    logic                  flush;
  } item_t;

  localparam logic [PrefixLenBits-1:0] LenRaw  = 4'd0;
  localparam logic [PrefixLenBits-1:0] LenSame = 4'd1;
  localparam logic [PrefixLenBits-1:0] LenFit  = 4'd2;
  localparam logic [PrefixLenBits-1:0] LenNew  = 4'd14;
  localparam logic [1:0]               CodeFit = 2'b10;
  localparam logic [1:0]               CodeNew = 2'b11;

  function automatic logic [CountBits-1:0] count_leading(input logic [WordBits-1:0] v);
    logic [3:0]           byte_lz [8];
    logic [CountBits-1:0] n;
    logic                 found;
    for (int b = 0; b < 8; b++) begin
      byte_lz[b] = 4'd8;
      for (int k = 0; k < 8; k++) begin
        if (v[b*8+k]) begin
          byte_lz[b] = 4'(7 - k);
        end
      end
    end
    n     = 7'(WordBits);
    found = 1'b0;
    for (int b = 7; b >= 0; b--) begin
      if (!found && byte_lz[b] != 4'd8) begin
        n     = 7'((7 - b) * 8) + 7'(byte_lz[b]);
        found = 1'b1;
      end
    end
    return n;
  endfunction

  function automatic logic [CountBits-1:0] count_trailing(input logic [WordBits-1:0] v);
    logic [3:0]           byte_tz [8];
    logic [CountBits-1:0] n;
    logic                 found;
    for (int b = 0; b < 8; b++) begin
      byte_tz[b] = 4'd8;
      for (int k = 7; k >= 0; k--) begin
        if (v[b*8+k]) begin
          byte_tz[b] = 4'(k);
        end
      end
    end
    n     = 7'(WordBits);
    found = 1'b0;
    for (int b = 0; b < 8; b++) begin
      if (!found && byte_tz[b] != 4'd8) begin
        n     = 7'(b * 8) + 7'(byte_tz[b]);
        found = 1'b1;
      end
    end
    return n;
  endfunction

endpackage

// ----- rtl/core/xvse_front.sv -----
`timescale 1ns / 1ps
// Front end of the encoder: accepts input transactions, XORs each word with
// the previous one and classifies it. Depends on xvse_pkg.
module xvse_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [xvse_pkg::WordBits-1:0]  word,
  input  logic                           first_of_series,
  input  logic                           last_of_series,
  input  logic                           queue_full,
  output logic                           push,
  output xvse_pkg::item_t                push_item
);
  import xvse_pkg::*;

  logic [WordBits-1:0]  previous_word;
  logic [WordBits-1:0]  diff;
  logic [WordBits-1:0]  subject;
  logic [CountBits-1:0] lead_count;
  logic [CountBits-1:0] trail_count;

  assign in_stall = queue_full;
  assign push     = in_valid && !queue_full;

  assign diff        = previous_word ^ word;
  assign subject     = first_of_series ? word : diff;
  assign lead_count  = count_leading(subject);
  assign trail_count = count_trailing(subject);

  always_comb begin
    push_item.value = subject;
    push_item.flush = last_of_series;
    push_item.lead  = lead_count[ScopeBits-1:0];
    push_item.trail = trail_count[ScopeBits-1:0];
    if (first_of_series) begin
      push_item.kind = KIND_RAW;
      if (word == '0) begin
        push_item.lead  = '0;
        push_item.trail = '0;
      end
    end else if (diff == '0) begin
      push_item.kind = KIND_SAME;
    end else begin
      push_item.kind = KIND_DIFF;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_word <= '0;
    end else if (push) begin
      previous_word <= word;
    end
  end

endmodule

// ----- rtl/core/xvse_queue.sv -----
`timescale 1ns / 1ps
// Two-entry queue between the front and back ends of the encoder.
// Depends on xvse_pkg for the item type.
module xvse_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  xvse_pkg::item_t push_item,
  output logic            full,
  output logic            not_empty,
  input  logic            pop,
  output xvse_pkg::item_t pop_item
);
  import xvse_pkg::*;

  item_t      entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign pop_item  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("Queue occupancy beyond two entries.");
  assert property (@(posedge clk) disable iff (rst) pop |-> count != 2'd0)
    else $error("Queue popped while empty.");
  assert property (@(posedge clk) disable iff (rst) push |-> count != 2'd2)
    else $error("Queue pushed while full.");
  assert property (@(posedge clk) disable iff (rst)
    (count == 2'd0 || count == 2'd2) |-> wr_ptr == rd_ptr)
    else $error("Queue pointers disagree with occupancy.");

endmodule

// ----- rtl/core/xvse_back.sv -----
`timescale 1ns / 1ps
// Back end of the encoder: holds the scope, forms the prefix and payload of
// each code word and drives the output register. Depends on xvse_pkg.
module xvse_back (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                not_empty,
  input  xvse_pkg::item_t                     item,
  output logic                                pop,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [xvse_pkg::PrefixBits-1:0]     prefix_bits,
  output logic [xvse_pkg::PrefixLenBits-1:0]  prefix_length,
  output logic [xvse_pkg::WordBits-1:0]       payload_bits,
  output logic [xvse_pkg::CountBits-1:0]      payload_length,
  output logic                                flush_after
);
  import xvse_pkg::*;

  logic [ScopeBits-1:0]     scope_lead;
  logic [ScopeBits-1:0]     scope_trail;
  logic                     fits;
  logic [CountBits-1:0]     fit_len;
  logic [CountBits-1:0]     new_len;
  logic [PrefixBits-1:0]    prefix_next;
  logic [PrefixLenBits-1:0] prefix_len_next;
  logic [WordBits-1:0]      payload_next;
  logic [CountBits-1:0]     payload_len_next;

  assign pop = not_empty && (!out_valid || !out_stall);

  assign fits    = (item.lead >= scope_lead) && (item.trail >= scope_trail);
  assign fit_len = 7'(WordBits) - 7'(scope_lead) - 7'(scope_trail);
  assign new_len = 7'(WordBits) - 7'(item.lead) - 7'(item.trail);

  always_comb begin
    prefix_next      = '0;
    prefix_len_next  = LenRaw;
    payload_next     = '0;
    payload_len_next = '0;
    unique case (item.kind)
      KIND_RAW: begin
        payload_next     = item.value;
        payload_len_next = 7'(WordBits);
      end
      KIND_SAME: begin
        prefix_len_next = LenSame;
      end
      KIND_DIFF: begin
        if (fits) begin
          prefix_next      = 14'(CodeFit);
          prefix_len_next  = LenFit;
          payload_next     = item.value >> scope_trail;
          payload_len_next = fit_len;
        end else begin
          prefix_next      = {CodeNew, item.lead, 6'(new_len - 7'd1)};
          prefix_len_next  = LenNew;
          payload_next     = item.value >> item.trail;
          payload_len_next = new_len;
        end
      end
      default: begin
        prefix_len_next = LenRaw;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      prefix_bits    <= prefix_next;
      prefix_length  <= prefix_len_next;
      payload_bits   <= payload_next;
      payload_length <= payload_len_next;
      flush_after    <= item.flush;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      scope_lead  <= '0;
      scope_trail <= '0;
    end else begin
      if (pop) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (pop && item.kind != KIND_SAME) begin
        scope_lead  <= item.lead;
        scope_trail <= item.trail;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    ({1'b0, scope_lead} + {1'b0, scope_trail}) <= 7'd63)
    else $error("Stored scope sums past 63.");
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (prefix_length == LenRaw && payload_length == 7'(WordBits))
               || (prefix_length == LenSame && payload_length == 7'd0)
               || (prefix_length == LenFit && payload_length != 7'd0)
               || (prefix_length == LenNew && payload_length != 7'd0))
    else $error("Prefix and payload lengths disagree.");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && prefix_length == LenNew)
      |-> payload_length == 7'(prefix_bits[ScopeBits-1:0]) + 7'd1)
    else $error("Length field does not match payload length.");
  assert property (@(posedge clk) disable iff (rst)
    (pop && item.kind == KIND_SAME) |=> $stable(scope_lead) && $stable(scope_trail))
    else $error("Scope changed on an identical word.");

endmodule

// ----- rtl/core/xor_value_stream_encoder.sv -----
`timescale 1ns / 1ps
// XOR value stream encoder, top level. A transaction on the input side takes
// one 64-bit word at a rate of one per clock cycle; each word leaves via the
// queue and the output register as one code word (prefix and payload,
// right-aligned, MSB first), one per cycle while the output is not stalled.
// The front end computes the XOR with the previous word and its zero counts,
// a two-entry queue decouples it from the back end, which applies the stored
// scope and loads the output register. The input stalls only when that
// queue is full. Depends on xvse_pkg, xvse_front, xvse_queue and xvse_back.
module xor_value_stream_encoder (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [xvse_pkg::WordBits-1:0]       word,
  input  logic                                first_of_series,
  input  logic                                last_of_series,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [xvse_pkg::PrefixBits-1:0]     prefix_bits,
  output logic [xvse_pkg::PrefixLenBits-1:0]  prefix_length,
  output logic [xvse_pkg::WordBits-1:0]       payload_bits,
  output logic [xvse_pkg::CountBits-1:0]      payload_length,
  output logic                                flush_after
);
  import xvse_pkg::*;

  logic  push;
  logic  pop;
  logic  queue_full;
  logic  queue_not_empty;
  item_t push_item;
  item_t pop_item;

  xvse_front u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .word            (word),
    .first_of_series (first_of_series),
    .last_of_series  (last_of_series),
    .queue_full      (queue_full),
    .push            (push),
    .push_item       (push_item)
  );

  xvse_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (queue_full),
    .not_empty (queue_not_empty),
    .pop       (pop),
    .pop_item  (pop_item)
  );

  xvse_back u_back (
    .clk            (clk),
    .rst            (rst),
    .not_empty      (queue_not_empty),
    .item           (pop_item),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .prefix_bits    (prefix_bits),
    .prefix_length  (prefix_length),
    .payload_bits   (payload_bits),
    .payload_length (payload_length),
    .flush_after    (flush_after)
  );

endmodule

// ----- test/xor_value_stream_encoder_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for xor_value_stream_encoder: directed and random word series,
// with a scoreboard that predicts each code word. Depends on xvse_pkg and the encoder RTL.

typedef struct packed {
  logic [xvse_pkg::PrefixBits-1:0]    prefix;
  logic [xvse_pkg::PrefixLenBits-1:0] prefix_len;
  logic [xvse_pkg::WordBits-1:0]      payload;
  logic [xvse_pkg::CountBits-1:0]     payload_len;
  logic                               flush;
} code_word_t;

class code_word_checker;
  logic [xvse_pkg::WordBits-1:0]  prev_word;
  logic [xvse_pkg::CountBits-1:0] scope_lead;
  logic [xvse_pkg::CountBits-1:0] scope_trail;
  code_word_t                     expected_codes[$];
  int                             errors;

  function new();
    prev_word   = '0;
    scope_lead  = '0;
    scope_trail = '0;
    errors      = 0;
  endfunction

  function int leading_zeros(logic [63:0] v);
    int n = 0;
    while (n < 64 && !v[63-n]) n++;
    return n;
  endfunction

  function int trailing_zeros(logic [63:0] v);
    int n = 0;
    while (n < 64 && !v[n]) n++;
    return n;
  endfunction

  function int pending();
    return expected_codes.size();
  endfunction

  // Works out the code word for one accepted transaction and updates the scope.
  function void note_word(logic [63:0] w, logic first, logic last);
    code_word_t  c;
    logic [63:0] x;
    int          lz;
    int          tz;
    int          sum;
    int          len;
    c       = '0;
    c.flush = last;
    if (first) begin
      c.prefix_len  = xvse_pkg::LenRaw;
      c.payload     = w;
      c.payload_len = 7'd64;
      if (w == '0) begin
        scope_lead  = '0;
        scope_trail = '0;
      end else begin
        scope_lead  = 7'(leading_zeros(w));
        scope_trail = 7'(trailing_zeros(w));
      end
    end else begin
      x = prev_word ^ w;
      if (x == '0) begin
        c.prefix_len = xvse_pkg::LenSame;
      end else begin
        lz = leading_zeros(x);
        tz = trailing_zeros(x);
        if (lz >= int'(scope_lead) && tz >= int'(scope_trail)) begin
          sum = int'(scope_lead) + int'(scope_trail);
          len = (sum >= 64) ? 1 : 64 - sum;
          c.payload = x >> (scope_trail & 7'd63);
          if (len < 64) c.payload &= (64'd1 << len) - 64'd1;
          c.payload_len = 7'(len);
          c.prefix      = 14'(xvse_pkg::CodeFit);
          c.prefix_len  = xvse_pkg::LenFit;
        end else begin
          len           = 64 - lz - tz;
          c.prefix      = {xvse_pkg::CodeNew, 6'(lz), 6'(len - 1)};
          c.prefix_len  = xvse_pkg::LenNew;
          c.payload     = x >> tz;
          c.payload_len = 7'(len);
        end
        scope_lead  = 7'(lz);
        scope_trail = 7'(tz);
      end
    end
    prev_word = w;
    expected_codes.push_back(c);
  endfunction

  task report_mismatch(string msg);
    if (errors < 50) $display("mismatch: %s", msg);
    errors++;
  endtask

  task check_code(code_word_t got);
    code_word_t e;
    if (expected_codes.size() == 0) begin
      report_mismatch($sformatf("unexpected code word %h", got));
      return;
    end
    e = expected_codes.pop_front();
    if (got.prefix != e.prefix)
      report_mismatch($sformatf("prefix_bits %h, expected %h", got.prefix, e.prefix));
    if (got.prefix_len != e.prefix_len)
      report_mismatch($sformatf("prefix_length %0d, expected %0d",
                                got.prefix_len, e.prefix_len));
    if (got.payload != e.payload)
      report_mismatch($sformatf("payload_bits %h, expected %h", got.payload, e.payload));
    if (got.payload_len != e.payload_len)
      report_mismatch($sformatf("payload_length %0d, expected %0d",
                                got.payload_len, e.payload_len));
    if (got.flush != e.flush)
      report_mismatch($sformatf("flush_after %0b, expected %0b", got.flush, e.flush));
  endtask
endclass

module xor_value_stream_encoder_test;
  localparam int CycleLimit = 400000;
  localparam int RandomItems = 1200;

  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic                                in_valid = 1'b0;
  logic                                in_stall;
  logic [xvse_pkg::WordBits-1:0]       word = '0;
  logic                                first_of_series = 1'b0;
  logic                                last_of_series = 1'b0;
  logic                                out_valid;
  logic                                out_stall = 1'b0;
  logic [xvse_pkg::PrefixBits-1:0]     prefix_bits;
  logic [xvse_pkg::PrefixLenBits-1:0]  prefix_length;
  logic [xvse_pkg::WordBits-1:0]       payload_bits;
  logic [xvse_pkg::CountBits-1:0]      payload_length;
  logic                                flush_after;

  bit               no_idle = 1'b0;
  int               cycles = 0;
  code_word_checker codes = new();

  xor_value_stream_encoder dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .word           (word),
    .first_of_series(first_of_series),
    .last_of_series (last_of_series),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .prefix_bits    (prefix_bits),
    .prefix_length  (prefix_length),
    .payload_bits   (payload_bits),
    .payload_length (payload_length),
    .flush_after    (flush_after)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      codes.check_code({prefix_bits, prefix_length, payload_bits, payload_length, flush_after});
  end

  initial begin
    int n;
    @(negedge clk);
    forever begin
      n = no_idle ? 0 : $urandom_range(0, 4);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
      @(negedge clk);
    end
  end

  function automatic logic [63:0] random_word();
    return {$urandom(), $urandom()};
  endfunction

  task automatic send_word(input logic [63:0] w, input logic first, input logic last);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid        <= 1'b1;
    word            <= w;
    first_of_series <= first;
    last_of_series  <= last;
    do @(posedge clk); while (in_stall);
    codes.note_word(w, first, last);
  endtask

  initial begin
    logic [63:0] w;
    logic [63:0] mask;
    int          issued;
    int          run;
    int          lo;
    int          hi;
    int          pick;
    logic        last;
    issued = 0;
    repeat (7) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Words before any series start are coded against a zero word and an empty scope.
    send_word(64'h0, 1'b0, 1'b0);
    send_word(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0);
    send_word(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1);
    send_word(64'h0, 1'b1, 1'b0);
    send_word(64'h1, 1'b0, 1'b0);
    send_word(64'h3, 1'b0, 1'b0);
    send_word(64'h8000_0000_0000_0003, 1'b1, 1'b1);
    send_word(64'h0000_0000_0000_0003, 1'b0, 1'b0);
    send_word(64'h0123_4567_89AB_CDEF, 1'b1, 1'b0);
    send_word(64'h0123_4567_89AB_CDEF, 1'b0, 1'b0);
    send_word(64'h0123_4A67_89AB_CDEF, 1'b0, 1'b0);
    send_word(64'h0123_4C67_89AB_CDEF, 1'b0, 1'b0);
    send_word(64'hF123_4C67_89AB_CDEE, 1'b0, 1'b1);
    send_word(64'h8000_0000_0000_0000, 1'b1, 1'b0);
    send_word(64'h0, 1'b0, 1'b0);
    send_word(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0);
    send_word(64'h7FFF_FFFF_FFFF_FFFE, 1'b0, 1'b0);
    send_word(64'h7FFF_FFFF_FFFF_FFFE, 1'b0, 1'b1);

    // Random series: mostly small changes inside a drifting bit window, with noise.
    while (issued < RandomItems) begin
      no_idle = ($urandom_range(0, 4) == 0);
      pick    = $urandom_range(0, 9);
      w       = (pick == 0) ? 64'h0 : (pick == 1) ? 64'hFFFF_FFFF_FFFF_FFFF : random_word();
      run     = $urandom_range(1, 24);
      lo      = $urandom_range(0, 63);
      hi      = $urandom_range(lo, 63);
      send_word(w, $urandom_range(0, 9) != 0, run == 1);
      issued++;
      for (int k = 1; k < run; k++) begin
        pick = $urandom_range(0, 99);
        if (pick >= 20 && pick < 85) begin
          if (pick >= 70) begin
            lo = $urandom_range(0, 63);
            hi = $urandom_range(lo, 63);
          end else if ($urandom_range(0, 3) == 0 && lo < hi) begin
            if ($urandom_range(0, 1) == 0) lo++;
            else hi--;
          end
          mask = ({64{1'b1}} << lo) & ({64{1'b1}} >> (63 - hi));
          w    = w ^ (random_word() & mask);
        end else if (pick >= 85 && pick < 95) begin
          w = random_word();
        end else if (pick >= 95) begin
          w = w ^ (64'd1 << $urandom_range(0, 63));
        end
        last = (k == run - 1) || ($urandom_range(0, 19) == 0);
        send_word(w, $urandom_range(0, 49) == 0, last);
        issued++;
      end
    end
    @(negedge clk) in_valid <= 1'b0;
    no_idle = 1'b0;

    while (codes.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (codes.errors == 0 && codes.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
